### design/assert_macros.svh
// Assertion macros used by the checker file of the scheduler.
// Depends on nothing; each macro expands to one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

### design/mlqs_pkg.sv
// Package of the multilevel queue scheduler: sizes, beat types and states.
// Depends on nothing; used by every module of the block.
package mlqs_pkg;

   localparam int MAX_PROCS = 16;
   localparam int IDX_W     = $clog2(MAX_PROCS);
   localparam int CNT_W     = IDX_W + 1;
   localparam int TIME_W    = 16;
   localparam int VAL_W     = 8;
   localparam logic [VAL_W-1:0] DEFAULT_QUANTUM = 8'd2;

   typedef struct packed {
      logic [VAL_W-1:0] arrival;
      logic [VAL_W-1:0] burst;
      logic             level;
      logic             final_entry;
   } req_type;

   typedef struct packed {
      logic [3:0]        process_index;
      logic [TIME_W-1:0] completion;
      logic [TIME_W-1:0] turnaround;
      logic [TIME_W-1:0] waiting;
      logic              last_result;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_DECIDE,
      ST_SCAN,
      ST_ADMIT,
      ST_REQUEUE,
      ST_PICK,
      ST_OUT
   } state_type;

endpackage

### design/mlqs_fifo.sv
// Circular ready queue of process indices with push, pop and a flush.
// Depends on mlqs_pkg for the index and count widths.
module mlqs_fifo
   import mlqs_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             clear,
   input  logic             push,
   input  logic [IDX_W-1:0] push_data,
   input  logic             pop,
   output logic [IDX_W-1:0] head_data,
   output logic             empty
);

   logic [IDX_W-1:0] slot_ff [MAX_PROCS];
   logic [IDX_W-1:0] head_ff, head_in;
   logic [IDX_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] count_ff, count_in;

   // Pointer and count update; a flush empties the queue at once.
   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (clear) begin
         head_in  = '0;
         tail_in  = '0;
         count_in = '0;
      end else begin
         if (push) begin
            tail_in = tail_ff + 1'b1;
         end
         if (pop) begin
            head_in = head_ff + 1'b1;
         end
         count_in = count_ff + CNT_W'(push) - CNT_W'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (push && !clear) begin
         slot_ff[tail_ff] <= push_data;
      end
   end

   assign head_data = slot_ff[head_ff];
   assign empty     = (count_ff == '0);

endmodule

### design/multilevel_queue_scheduler_top.sv
// Multilevel queue scheduler: each request beat loads one process (one beat per
// cycle in ST_LOAD, up to MAX_PROCS kept, later ones dropped). The beat marked
// final_entry starts a simulation run by a small sequencer around one shared
// compare unit: every decision point scans the loaded processes once per admitted
// process plus once per level, then passes through ST_REQUEUE and ST_PICK to
// requeue and run. Results then leave one per response beat in index order; a
// new load may start as the last result waits in the output register. The round
// robin slice length is written through csr_wr_en.
// Depends on mlqs_pkg and mlqs_fifo.
module multilevel_queue_scheduler_top
   import mlqs_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsp_type          rsp_data,
   input  logic             csr_wr_en,
   input  logic [VAL_W-1:0] csr_wr_data
);

   // Process store.
   logic [VAL_W-1:0]  arrival_ff   [MAX_PROCS];
   logic [VAL_W-1:0]  burst_ff     [MAX_PROCS];
   logic [VAL_W-1:0]  remaining_ff [MAX_PROCS];
   logic              level_ff     [MAX_PROCS];
   logic [TIME_W-1:0] completion_ff[MAX_PROCS];
   logic [MAX_PROCS-1:0] admitted_ff;

   // Sequencer registers.
   state_type         state_ff, state_in;
   logic [VAL_W-1:0]  quantum_ff;
   logic [CNT_W-1:0]  loaded_ff, loaded_in;
   logic [CNT_W-1:0]  done_ff, done_in;
   logic [TIME_W-1:0] now_ff, now_in;
   logic [IDX_W-1:0]  run_slot_ff, run_slot_in;
   logic              run_valid_ff, run_valid_in;
   logic              lvl_ff, lvl_in;
   logic [IDX_W-1:0]  scan_ff, scan_in;
   logic [IDX_W-1:0]  best_ff, best_in;
   logic [VAL_W-1:0]  best_arr_ff, best_arr_in;
   logic              best_valid_ff, best_valid_in;
   logic [IDX_W-1:0]  out_ff, out_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   // Strobes and shared datapath.
   logic              req_fire;
   logic              load_we;
   logic [IDX_W-1:0]  load_idx;
   logic              rem_we;
   logic [VAL_W-1:0]  rem_wdata;
   logic              cmp_we;
   logic              adm_set;
   logic              clear_run;
   logic [IDX_W-1:0]  sel_idx;
   logic              candidate;
   logic              scan_last;
   logic              hi_push, hi_pop, lo_pop;
   logic [IDX_W-1:0]  hi_push_data, hi_head, lo_head;
   logic              hi_empty, lo_empty;
   logic [VAL_W-1:0]  q_eff, rem_rd, run_len;
   logic [TIME_W-1:0] turn_calc;

   assign req_fire = req_valid && req_ready;
   assign load_idx = loaded_ff[IDX_W-1:0];
   assign q_eff    = (quantum_ff == '0) ? VAL_W'(1) : quantum_ff;
   assign rem_rd   = remaining_ff[sel_idx];
   assign run_len  = (rem_rd < q_eff) ? rem_rd : q_eff;
   assign scan_last = ({1'b0, scan_ff} == loaded_ff - 1'b1);

   // Shared compare unit: is the scanned process a better admission pick.
   assign candidate = !admitted_ff[sel_idx] && (level_ff[sel_idx] == lvl_ff)
                      && ({8'd0, arrival_ff[sel_idx]} <= now_ff)
                      && (!best_valid_ff || (arrival_ff[sel_idx] < best_arr_ff));

   assign turn_calc = completion_ff[sel_idx] - TIME_W'(arrival_ff[sel_idx]);

   mlqs_fifo u_high_fifo (
      .clock     (clock),
      .reset     (reset),
      .clear     (clear_run),
      .push      (hi_push),
      .push_data (hi_push_data),
      .pop       (hi_pop),
      .head_data (hi_head),
      .empty     (hi_empty)
   );

   mlqs_fifo u_low_fifo (
      .clock     (clock),
      .reset     (reset),
      .clear     (clear_run),
      .push      (adm_set && lvl_ff),
      .push_data (best_ff),
      .pop       (lo_pop),
      .head_data (lo_head),
      .empty     (lo_empty)
   );

   // Next state and sequencer outputs.
   always_comb begin
      state_in      = state_ff;
      loaded_in     = loaded_ff;
      done_in       = done_ff;
      now_in        = now_ff;
      run_slot_in   = run_slot_ff;
      run_valid_in  = run_valid_ff;
      lvl_in        = lvl_ff;
      scan_in       = scan_ff;
      best_in       = best_ff;
      best_arr_in   = best_arr_ff;
      best_valid_in = best_valid_ff;
      out_in        = out_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_in        = rsp_ff;
      req_ready     = 1'b0;
      load_we       = 1'b0;
      rem_we        = 1'b0;
      rem_wdata     = rem_rd;
      cmp_we        = 1'b0;
      adm_set       = 1'b0;
      clear_run     = 1'b0;
      sel_idx       = scan_ff;
      hi_push       = 1'b0;
      hi_push_data  = best_ff;
      hi_pop        = 1'b0;
      lo_pop        = 1'b0;
      unique case (state_ff)
         ST_LOAD: begin
            req_ready = 1'b1;
            if (req_fire) begin
               if (loaded_ff < CNT_W'(MAX_PROCS)) begin
                  load_we   = 1'b1;
                  loaded_in = loaded_ff + 1'b1;
               end
               if (req_data.final_entry) begin
                  state_in = ST_DECIDE;
               end
            end
         end
         ST_DECIDE: begin
            if (done_ff == loaded_ff) begin
               out_in   = '0;
               state_in = ST_OUT;
            end else begin
               lvl_in        = 1'b0;
               scan_in       = '0;
               best_valid_in = 1'b0;
               state_in      = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (candidate) begin
               best_in       = scan_ff;
               best_arr_in   = arrival_ff[sel_idx];
               best_valid_in = 1'b1;
            end
            scan_in = scan_ff + 1'b1;
            if (scan_last) begin
               state_in = ST_ADMIT;
            end
         end
         ST_ADMIT: begin
            scan_in       = '0;
            best_valid_in = 1'b0;
            state_in      = ST_SCAN;
            if (best_valid_ff) begin
               adm_set = 1'b1;
               hi_push = !lvl_ff;
            end else if (!lvl_ff) begin
               lvl_in = 1'b1;
            end else begin
               state_in = ST_REQUEUE;
            end
         end
         ST_REQUEUE: begin
            hi_push      = run_valid_ff;
            hi_push_data = run_slot_ff;
            state_in     = ST_PICK;
         end
         ST_PICK: begin
            state_in = ST_DECIDE;
            if (!hi_empty) begin
               sel_idx     = hi_head;
               hi_pop      = 1'b1;
               rem_we      = 1'b1;
               rem_wdata   = rem_rd - run_len;
               now_in      = now_ff + TIME_W'(run_len);
               run_slot_in = hi_head;
               if (rem_rd == run_len) begin
                  cmp_we       = 1'b1;
                  done_in      = done_ff + 1'b1;
                  run_valid_in = 1'b0;
               end else begin
                  run_valid_in = 1'b1;
               end
            end else if (!lo_empty) begin
               sel_idx   = lo_head;
               now_in    = now_ff + 1'b1;
               rem_we    = 1'b1;
               rem_wdata = (rem_rd == '0) ? '0 : rem_rd - 1'b1;
               if (rem_rd <= VAL_W'(1)) begin
                  cmp_we  = 1'b1;
                  done_in = done_ff + 1'b1;
                  lo_pop  = 1'b1;
               end
            end else begin
               now_in = now_ff + 1'b1;
            end
         end
         ST_OUT: begin
            sel_idx = out_ff;
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in         = 1'b1;
               rsp_in.process_index = 4'(out_ff);
               rsp_in.completion    = completion_ff[sel_idx];
               rsp_in.turnaround    = turn_calc;
               rsp_in.waiting       = turn_calc - TIME_W'(burst_ff[sel_idx]);
               rsp_in.last_result   = ({1'b0, out_ff} == loaded_ff - 1'b1);
               out_in               = out_ff + 1'b1;
               if (rsp_in.last_result) begin
                  clear_run    = 1'b1;
                  loaded_in    = '0;
                  done_in      = '0;
                  now_in       = '0;
                  run_slot_in  = '0;
                  run_valid_in = 1'b0;
                  state_in     = ST_LOAD;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_LOAD;
         quantum_ff    <= DEFAULT_QUANTUM;
         loaded_ff     <= '0;
         done_ff       <= '0;
         now_ff        <= '0;
         run_slot_ff   <= '0;
         run_valid_ff  <= 1'b0;
         lvl_ff        <= 1'b0;
         scan_ff       <= '0;
         best_valid_ff <= 1'b0;
         out_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
         admitted_ff   <= '0;
      end else begin
         state_ff      <= state_in;
         if (csr_wr_en) begin
            quantum_ff <= csr_wr_data;
         end
         loaded_ff     <= loaded_in;
         done_ff       <= done_in;
         now_ff        <= now_in;
         run_slot_ff   <= run_slot_in;
         run_valid_ff  <= run_valid_in;
         lvl_ff        <= lvl_in;
         scan_ff       <= scan_in;
         best_valid_ff <= best_valid_in;
         out_ff        <= out_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (clear_run) begin
            admitted_ff <= '0;
         end else if (adm_set) begin
            admitted_ff[best_ff] <= 1'b1;
         end
      end
   end

   // Payload registers and process store.
   always_ff @(posedge clock) begin
      best_ff     <= best_in;
      best_arr_ff <= best_arr_in;
      rsp_ff      <= rsp_in;
      if (load_we) begin
         arrival_ff[load_idx]   <= req_data.arrival;
         burst_ff[load_idx]     <= req_data.burst;
         remaining_ff[load_idx] <= req_data.burst;
         level_ff[load_idx]     <= req_data.level;
      end else if (rem_we) begin
         remaining_ff[sel_idx] <= rem_wdata;
      end
      if (cmp_we) begin
         completion_ff[sel_idx] <= now_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

### design/mlqs_checker.sv
// Port-level checker of the multilevel queue scheduler and its bind.
// Depends on mlqs_pkg and the macros in assert_macros.svh.
`include "assert_macros.svh"

module mlqs_checker
   import mlqs_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // A stalled result beat holds.
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))

   // The final load beat starts a run, so no request is taken next cycle.
   `ASSERT_NEXT(a_final_busy, clock, reset, req_valid && req_ready && req_data.final_entry, !req_ready)

   // Loading resumes only once the last result is in the output register.
   `ASSERT_IMPLIES(a_no_load_mid_out, clock, reset, rsp_valid && !rsp_data.last_result, !req_ready)

   // After the last result is taken no stray result follows.
   `ASSERT_NEXT(a_last_ends, clock, reset, rsp_valid && rsp_ready && rsp_data.last_result, !rsp_valid)

   // A process never completes before it arrived.
   `ASSERT_IMPLIES(a_turn_bound, clock, reset, rsp_valid, rsp_data.turnaround <= rsp_data.completion)

endmodule

bind multilevel_queue_scheduler_top mlqs_checker u_mlqs_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
